FILE: rtl/core/itda_pkg.sv
// ---------------------------------------------------------------------------
// itda_pkg
// Shared constants and helpers for the integer to decimal text converter.
// ---------------------------------------------------------------------------
`default_nettype none

package itda_pkg;

  // ascii codes
  localparam logic [7:0] ASCII_ZERO  = 8'h30;
  localparam logic [7:0] ASCII_MINUS = 8'h2D;

  // width of one bcd digit
  localparam int BCD_W = 4;

  // decimal digits needed for an unsigned word of the given width
  // (floor(bits * log10(2)) + 1, log10(2) taken as 0.30103)
  function automatic int itda_digits(input int bits);
    return (bits * 30103) / 100000 + 1;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/core/itda_if.sv
// ---------------------------------------------------------------------------
// itda_in_if / itda_out_if
// Valid/ready channels carrying the input word and the output characters.
// ---------------------------------------------------------------------------
`default_nettype none

interface itda_in_if #(
  parameter int VALUE_BITS = 32
);
  logic                  valid;
  logic                  ready;
  logic [VALUE_BITS-1:0] value;
  logic                  is_signed;

  modport source (output valid, output value, output is_signed, input ready);
  modport sink   (input valid, input value, input is_signed, output ready);
endinterface

interface itda_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] digit_char;
  logic       last_char;

  modport source (output valid, output digit_char, output last_char, input ready);
  modport sink   (input valid, input digit_char, input last_char, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/itda_front.sv
// ---------------------------------------------------------------------------
// itda_front
// Accepts input words, finds the sign and forms the magnitude.
// ---------------------------------------------------------------------------
`default_nettype none

module itda_front #(
  parameter int VALUE_BITS = 32
) (
  itda_in_if.sink               in_chan,
  input  wire logic             q_full,
  output logic                  q_push,
  output logic [VALUE_BITS:0]   q_data
);

  logic                  neg;
  logic [VALUE_BITS-1:0] mag;

  always_comb begin
    neg = in_chan.is_signed & in_chan.value[VALUE_BITS-1];
    // two's complement negate; the most negative value maps onto itself,
    // which read unsigned is the exact magnitude
    if (neg) begin
      mag = (~in_chan.value) + VALUE_BITS'(1);
    end else begin
      mag = in_chan.value;
    end
  end

  assign in_chan.ready = ~q_full;
  assign q_push        = in_chan.valid & ~q_full;
  assign q_data        = {neg, mag};

endmodule

`default_nettype wire

FILE: rtl/core/itda_queue.sv
// ---------------------------------------------------------------------------
// itda_queue
// Two-entry queue between the front and the back.
// ---------------------------------------------------------------------------
`default_nettype none

module itda_queue #(
  parameter int WIDTH = 33
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] push_data,
  input  wire logic             pop,
  output logic                  full,
  output logic                  empty,
  output logic [WIDTH-1:0]      pop_data
);

  logic [WIDTH-1:0] mem_r [2];
  logic             wr_ptr_r, wr_ptr_nxt;
  logic             rd_ptr_r, rd_ptr_nxt;
  logic [1:0]       count_r, count_nxt;

  assign full     = (count_r == 2'd2);
  assign empty    = (count_r == 2'd0);
  assign pop_data = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r ^ push;
    rd_ptr_nxt = rd_ptr_r ^ pop;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 2'd1;
    end else if (!push && pop) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full)
    else $error("queue written while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !empty)
    else $error("queue read while empty");

  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> (count_r == $past(count_r) + 2'd1))
    else $error("queue count did not follow a write");

endmodule

`default_nettype wire

FILE: rtl/core/itda_back.sv
// ---------------------------------------------------------------------------
// itda_back
// Serial binary to bcd conversion and character output, most significant first.
// ---------------------------------------------------------------------------
`default_nettype none

module itda_back
  import itda_pkg::*;
#(
  parameter int VALUE_BITS = 32,
  parameter int NDIG       = 10
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              q_empty,
  input  wire logic [VALUE_BITS:0] q_data,
  output logic                   q_pop,
  itda_out_if.source             out_chan
);

  localparam int          BCD_BITS = NDIG * BCD_W;
  localparam int          CNT_W    = $clog2(VALUE_BITS);
  localparam int          IDX_W    = $clog2(NDIG);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(VALUE_BITS - 1);
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(NDIG - 1);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_CONV = 3'd1;
  localparam logic [2:0] ST_SKIP = 3'd2;
  localparam logic [2:0] ST_SIGN = 3'd3;
  localparam logic [2:0] ST_EMIT = 3'd4;

  logic [2:0]            state_r, state_nxt;
  logic [VALUE_BITS-1:0] bin_r, bin_nxt;
  logic [BCD_BITS-1:0]   bcd_r, bcd_nxt;
  logic                  neg_r, neg_nxt;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic [IDX_W-1:0]      idx_r, idx_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [7:0]            out_char_r, out_char_nxt;
  logic                  out_last_r, out_last_nxt;

  logic [BCD_BITS-1:0]   bcd_adj;
  logic [BCD_W-1:0]      top_dig;
  logic                  slot_free;

  // add-3 correction on every digit before the shift
  always_comb begin
    for (int i = 0; i < NDIG; i++) begin
      if (bcd_r[i*BCD_W +: BCD_W] >= BCD_W'(5)) begin
        bcd_adj[i*BCD_W +: BCD_W] = bcd_r[i*BCD_W +: BCD_W] + BCD_W'(3);
      end else begin
        bcd_adj[i*BCD_W +: BCD_W] = bcd_r[i*BCD_W +: BCD_W];
      end
    end
  end

  assign top_dig   = bcd_r[BCD_BITS-1 -: BCD_W];
  assign slot_free = ~out_valid_r | out_chan.ready;
  assign q_pop     = (state_r == ST_IDLE) & ~q_empty;

  always_comb begin
    state_nxt     = state_r;
    bin_nxt       = bin_r;
    bcd_nxt       = bcd_r;
    neg_nxt       = neg_r;
    cnt_nxt       = cnt_r;
    idx_nxt       = idx_r;
    out_valid_nxt = out_valid_r & ~out_chan.ready;
    out_char_nxt  = out_char_r;
    out_last_nxt  = out_last_r;

    case (state_r)
      ST_IDLE: begin
        if (!q_empty) begin
          neg_nxt   = q_data[VALUE_BITS];
          bin_nxt   = q_data[VALUE_BITS-1:0];
          bcd_nxt   = '0;
          cnt_nxt   = '0;
          idx_nxt   = '0;
          state_nxt = ST_CONV;
        end
      end
      ST_CONV: begin
        bcd_nxt = {bcd_adj[BCD_BITS-2:0], bin_r[VALUE_BITS-1]};
        bin_nxt = {bin_r[VALUE_BITS-2:0], 1'b0};
        cnt_nxt = cnt_r + CNT_W'(1);
        if (cnt_r == CNT_LAST) begin
          state_nxt = ST_SKIP;
        end
      end
      ST_SKIP: begin
        // drop leading zeros, keeping at least the last digit
        if (top_dig == '0 && idx_r != IDX_LAST) begin
          bcd_nxt = {bcd_r[BCD_BITS-BCD_W-1:0], {BCD_W{1'b0}}};
          idx_nxt = idx_r + IDX_W'(1);
        end else if (neg_r) begin
          state_nxt = ST_SIGN;
        end else begin
          state_nxt = ST_EMIT;
        end
      end
      ST_SIGN: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = ASCII_MINUS;
          out_last_nxt  = 1'b0;
          state_nxt     = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = ASCII_ZERO + {4'b0000, top_dig};
          out_last_nxt  = (idx_r == IDX_LAST);
          bcd_nxt       = {bcd_r[BCD_BITS-BCD_W-1:0], {BCD_W{1'b0}}};
          idx_nxt       = idx_r + IDX_W'(1);
          if (idx_r == IDX_LAST) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    bin_r      <= bin_nxt;
    bcd_r      <= bcd_nxt;
    neg_r      <= neg_nxt;
    out_char_r <= out_char_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_chan.valid      = out_valid_r;
  assign out_chan.digit_char = out_char_r;
  assign out_chan.last_char  = out_last_r;

  a_quiet_while_converting: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CONV || state_r == ST_SKIP) |=> !$rose(out_valid_r))
    else $error("character issued before conversion finished");

  a_emit_is_digit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EMIT) |-> (top_dig <= BCD_W'(9)))
    else $error("bcd digit out of range");

  a_last_ends_number: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EMIT && slot_free && idx_r == IDX_LAST)
      |=> (state_r == ST_IDLE && out_valid_r && out_last_r))
    else $error("last character did not end the number");

endmodule

`default_nettype wire

FILE: rtl/core/integer_to_decimal_ascii.sv
// Flow: the word is registered into the queue, then the back runs a bit-serial
//   bcd conversion, skips leading zero digits and issues any minus sign and the digits,
//   one character per cycle while the output is ready. The back finishes one word
//   before it takes the next, set by the bit-serial double dabble loop in the back.
// Reset: synchronous active-low rst_n empties the queue, idles the converter
//   and drops the output word; no clearing pass.
// ---------------------------------------------------------------------------
// integer_to_decimal_ascii
// Converts a signed or unsigned word to decimal ascii text, one character per
// output word, most significant first, last character flagged.
// ---------------------------------------------------------------------------
`default_nettype none

module integer_to_decimal_ascii
  import itda_pkg::*;
#(
  parameter int VALUE_BITS = 32
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  itda_in_if.sink    in_chan,
  itda_out_if.source out_chan
);

  // number of decimal digit slots needed for the widest magnitude
  localparam int NDIG = itda_digits(VALUE_BITS);

  // queue entry is {negative flag, magnitude}
  logic                q_push;
  logic                q_pop;
  logic                q_full;
  logic                q_empty;
  logic [VALUE_BITS:0] q_wdata;
  logic [VALUE_BITS:0] q_rdata;

  // front: takes a word whenever the queue has room, works out sign and
  // magnitude in the same cycle
  itda_front #(
    .VALUE_BITS (VALUE_BITS)
  ) u_front (
    .in_chan (in_chan),
    .q_full  (q_full),
    .q_push  (q_push),
    .q_data  (q_wdata)
  );

  // two-entry queue so the front keeps taking words while the back
  // converts or waits on the output
  itda_queue #(
    .WIDTH (VALUE_BITS + 1)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_wdata),
    .pop       (q_pop),
    .full      (q_full),
    .empty     (q_empty),
    .pop_data  (q_rdata)
  );

  // back: double dabble one bit per cycle, leading zero skip, then the
  // sign and digits through a registered output word
  itda_back #(
    .VALUE_BITS (VALUE_BITS),
    .NDIG       (NDIG)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_empty  (q_empty),
    .q_data   (q_rdata),
    .q_pop    (q_pop),
    .out_chan (out_chan)
  );

endmodule

`default_nettype wire

FILE: tb/testbench.sv
// ---------------------------------------------------------------------------
// testbench
// Checks the integer to decimal text converter. Words are pushed in through
// the input channel with random gaps. Every character that comes out is
// compared with a predicted text held in a queue. The predicted text is
// formed from the same value and sign flag.
// ---------------------------------------------------------------------------
`default_nettype none

module testbench
  import itda_pkg::*;
();

  localparam int VALUE_BITS    = 32;
  localparam int RANDOM_WORDS  = 360;
  // limit covers the per-word conversion in the block, plus up to 11
  // characters each waiting out a long stall, plus long sender gaps
  localparam int CYCLE_LIMIT   = 1_000_000;
  localparam int DRAIN_CYCLES  = 2 * (VALUE_BITS + 13);
  localparam int HOLD_CYCLES   = 400;

  typedef struct packed {
    logic [VALUE_BITS-1:0] value;
    logic                  is_signed;
  } number_t;

  typedef struct packed {
    logic [7:0] digit_char;
    logic       last_char;
  } text_char_t;

  logic clk;
  logic rst_n;

  itda_in_if #(.VALUE_BITS(VALUE_BITS)) in_chan ();
  itda_out_if                           out_chan ();

  integer_to_decimal_ascii #(
    .VALUE_BITS(VALUE_BITS)
  ) DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  number_t    pending_numbers[$];   // words not yet offered
  text_char_t expected_chars[$];    // characters still owed by the block

  int  failures     = 0;
  int  chars_seen   = 0;
  int  words_sent   = 0;
  int  cycle_count  = 0;
  int  send_gap     = 0;
  int  stall_left   = 0;
  int  hold_left    = 0;
  int  hold_clock   = 0;
  bit  send_calm    = 1'b0;
  bit  recv_calm    = 1'b0;

  // clock, 12 units per period
  initial clk = 1'b0;
  always #6 clk = ~clk;

  // gap length: mostly none, some short, a few long; none in calm stretches
  function automatic int draw_gap(input bit calm);
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // decimal text of one word, most significant character first
  task automatic predict_text(input number_t num);
    logic [VALUE_BITS-1:0] mag;
    logic [7:0]            digits[$];
    bit                    negative;
    text_char_t            ch;
    negative = num.is_signed && num.value[VALUE_BITS-1];
    // two's complement wrap gives the right magnitude for the most negative word
    mag = negative ? (~num.value + 1'b1) : num.value;
    if (mag == '0) begin
      digits.push_front(ASCII_ZERO);
    end
    while (mag != '0) begin
      digits.push_front(ASCII_ZERO + 8'(mag % 10));
      mag = mag / 10;
    end
    if (negative) begin
      ch.digit_char = ASCII_MINUS;
      ch.last_char  = 1'b0;
      expected_chars.push_back(ch);
    end
    foreach (digits[i]) begin
      ch.digit_char = digits[i];
      ch.last_char  = (i == digits.size() - 1);
      expected_chars.push_back(ch);
    end
  endtask

  task automatic queue_number(input logic [VALUE_BITS-1:0] value, input logic is_signed);
    number_t num;
    num.value     = value;
    num.is_signed = is_signed;
    pending_numbers.push_back(num);
  endtask

  // driver: offers pending words, predicts the text of each accepted word
  always @(posedge clk) begin
    number_t num;
    if (!rst_n) begin
      in_chan.valid <= 1'b0;
    end else begin
      if (in_chan.valid && in_chan.ready) begin
        num.value     = in_chan.value;
        num.is_signed = in_chan.is_signed;
        predict_text(num);
        words_sent++;
        // alternate between stretches with and without idling
        if (words_sent % 40 == 0) send_calm = ~send_calm;
      end
      if (!in_chan.valid || in_chan.ready) begin
        if (send_gap > 0) begin
          send_gap--;
          in_chan.valid <= 1'b0;
        end else if (pending_numbers.size() > 0) begin
          num = pending_numbers.pop_front();
          in_chan.valid     <= 1'b1;
          in_chan.value     <= num.value;
          in_chan.is_signed <= num.is_signed;
          send_gap = draw_gap(send_calm);
        end else begin
          in_chan.valid <= 1'b0;
        end
      end
    end
  end

  // long receiver hold-offs, counted here, so the block fills and stalls its input
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_clock <= 0;
      hold_left  <= 0;
    end else begin
      hold_clock <= hold_clock + 1;
      if (hold_clock == 1500 || hold_clock == 9000) begin
        hold_left <= HOLD_CYCLES;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
      end
    end
  end

  // monitor: compares each character word with the oldest expectation
  always @(posedge clk) begin
    text_char_t want;
    if (!rst_n) begin
      out_chan.ready <= 1'b0;
    end else begin
      if (out_chan.valid && out_chan.ready) begin
        chars_seen++;
        if (expected_chars.size() == 0) begin
          failures++;
          $display("%0t: unexpected character: expected none, actual %h last %b",
                   $time, out_chan.digit_char, out_chan.last_char);
        end else begin
          want = expected_chars.pop_front();
          if (out_chan.digit_char !== want.digit_char ||
              out_chan.last_char !== want.last_char) begin
            failures++;
            $display("%0t: character mismatch: expected %h last %b, actual %h last %b",
                     $time, want.digit_char, want.last_char,
                     out_chan.digit_char, out_chan.last_char);
          end
        end
        if (chars_seen % 250 == 0) recv_calm = ~recv_calm;
        stall_left = draw_gap(recv_calm);
      end else if (stall_left == 0 && !recv_calm && $urandom_range(0, 29) == 0) begin
        // occasional stall while nothing is moving, to shift the phase
        stall_left = $urandom_range(1, 5);
      end
      if (hold_left > 0 || stall_left > 0) begin
        out_chan.ready <= 1'b0;
        if (stall_left > 0) stall_left--;
      end else begin
        out_chan.ready <= 1'b1;
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // stimulus, reset and end of run
  initial begin
    logic [VALUE_BITS-1:0] tens[10];
    logic [VALUE_BITS-1:0] v;
    int                    kind;

    rst_n             = 1'b0;
    in_chan.valid     = 1'b0;
    in_chan.value     = '0;
    in_chan.is_signed = 1'b0;
    out_chan.ready    = 1'b0;

    tens[0] = 1;
    for (int i = 1; i < 10; i++) tens[i] = tens[i-1] * 10;

    // directed: zero both ways, digit-count boundaries, extremes of both readings
    queue_number(32'd0, 1'b0);
    queue_number(32'd0, 1'b1);
    queue_number(32'd1, 1'b1);
    queue_number(32'd9, 1'b0);
    queue_number(32'd10, 1'b0);
    queue_number(32'd99, 1'b1);
    queue_number(32'd100, 1'b0);
    queue_number(32'd999_999_999, 1'b0);
    queue_number(32'd1_000_000_000, 1'b1);
    queue_number(32'hFFFF_FFFF, 1'b0);           // largest unsigned
    queue_number(32'hFFFF_FFFF, 1'b1);           // minus one
    queue_number(32'h8000_0000, 1'b1);           // most negative signed
    queue_number(32'h8000_0000, 1'b0);
    queue_number(32'h7FFF_FFFF, 1'b1);           // largest positive signed
    queue_number(32'h7FFF_FFFF, 1'b0);
    queue_number(32'h8000_0001, 1'b1);
    queue_number(-32'sd10, 1'b1);
    queue_number(-32'sd1_000_000_000, 1'b1);
    queue_number(32'd4_000_000_000, 1'b0);
    queue_number(32'hAAAA_AAAA, 1'b1);
    queue_number(32'h5555_5555, 1'b0);
    queue_number(32'hAAAA_AAAA, 1'b0);
    queue_number(32'h5555_5555, 1'b1);

    // random: full words, mixed lengths, small values, powers of ten, negatives
    for (int n = 0; n < RANDOM_WORDS; n++) begin
      kind = $urandom_range(0, 9);
      case (kind)
        0, 1, 2, 3: begin
          v = $urandom;
        end
        4, 5: begin
          v = $urandom >> $urandom_range(0, 31);
        end
        6: begin
          v = $urandom_range(0, 20);
        end
        7: begin
          v = tens[$urandom_range(0, 9)] + $urandom_range(0, 2) - 1;
        end
        8: begin
          v = -$urandom_range(1, 1000);
        end
        default: begin
          v = {1'b1, 31'($urandom >> $urandom_range(0, 31))};
        end
      endcase
      queue_number(v, 1'($urandom));
    end

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_numbers.size() != 0 || in_chan.valid || expected_chars.size() != 0)
      @(posedge clk);
    // catch any stray character after the last expected one
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (failures == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire

FILE: files.f
rtl/core/itda_pkg.sv
rtl/core/itda_if.sv
rtl/core/itda_front.sv
rtl/core/itda_queue.sv
rtl/core/itda_back.sv
rtl/core/integer_to_decimal_ascii.sv
tb/testbench.sv
